@@ rtl/bf3_pkg.sv @@
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types and constants for the 3x3 RGB box filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bf3_pkg;

   localparam logic       CMD_PIXEL  = 1'b0;
   localparam logic       CMD_FLUSH  = 1'b1;
   localparam int         SIZE_BITS  = 11;
   localparam int         SIZE_RESET = 64;
   localparam int         SIZE_MIN   = 2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_SUM    = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;   // restart frame, load new size
      logic load;    // capture request
      logic update;  // shift window, write line stores, advance input position
      logic sum;     // form clipped sums and reciprocal
      logic div;     // reciprocal multiply into quotient register
      logic emit;    // load result register, advance output position
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic in_done;   // all pixels of the frame are in
      logic emit_due;  // the pending update yields a result
      logic last_due;  // next result closes the frame
   } status_type;

endpackage

`default_nettype wire

@@ rtl/bf3_ctrl.sv @@
// ----------------------------------------------------------------------------
// bf3_ctrl
// Sequencer: one request at a time through update, sum, divide, output.
// ----------------------------------------------------------------------------
`default_nettype none

module bf3_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_cmd,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire bf3_pkg::status_type sts,
   output bf3_pkg::cmd_type         cmd
);

   bf3_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign req_stall = (state_ff != bf3_pkg::ST_IDLE);
   assign csr_ready = (state_ff == bf3_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         bf3_pkg::ST_IDLE: begin
            cmd.clear = csr_valid;
            if (req_valid) begin
               // early flush is dropped without effect
               if (!(req_cmd == bf3_pkg::CMD_FLUSH && !sts.in_done)) begin
                  cmd.load = 1'b1;
                  state_in = bf3_pkg::ST_UPDATE;
               end
            end
         end
         bf3_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = sts.emit_due ? bf3_pkg::ST_SUM : bf3_pkg::ST_IDLE;
         end
         bf3_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = bf3_pkg::ST_DIV;
         end
         bf3_pkg::ST_DIV: begin
            cmd.div  = 1'b1;
            state_in = bf3_pkg::ST_DONE;
         end
         bf3_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bf3_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bf3_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bf3_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bf3_dp.sv @@
// ----------------------------------------------------------------------------
// bf3_dp
// Datapath: line stores, 3x3 window, positions, clipped sums, divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bf3_dp #(
   parameter int MAX_DIM      = 1024,
   parameter int CHANNEL_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bf3_pkg::cmd_type                   cmd,
   output bf3_pkg::status_type                     sts,
   input  wire logic                               req_cmd,
   input  wire logic [15:0]                        req_in_red,
   input  wire logic [15:0]                        req_in_green,
   input  wire logic [15:0]                        req_in_blue,
   input  wire logic [bf3_pkg::SIZE_BITS-1:0]      csr_image_size,
   output logic [15:0]                             rsp_out_red,
   output logic [15:0]                             rsp_out_green,
   output logic [15:0]                             rsp_out_blue,
   output logic                                    rsp_frame_last
);

   localparam int CB        = CHANNEL_BITS;
   localparam int PXW       = 3 * CB;
   localparam int AW        = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int DW        = AW + 1;
   localparam int RW        = DW + 1;
   localparam int SW        = CB + 4;
   localparam int RESET_DIM = (bf3_pkg::SIZE_RESET > MAX_DIM) ? MAX_DIM : bf3_pkg::SIZE_RESET;

   // divide by 9, 6 or 4 as a multiply by ceil(2^QSHIFT / d), exact for 9 full sums
   localparam int              QSHIFT     = 24;
   localparam int              MW         = 23;
   localparam int              PW         = SW + MW;
   localparam logic [3:0]      DIV_INNER  = 4'd9;
   localparam logic [3:0]      DIV_EDGE   = 4'd6;
   localparam logic [MW-1:0]   RECIP_9    = MW'(1864136);
   localparam logic [MW-1:0]   RECIP_6    = MW'(2796203);
   localparam logic [MW-1:0]   RECIP_4    = MW'(4194304);

   logic [PXW-1:0] upper_mem [MAX_DIM];
   logic [PXW-1:0] lower_mem [MAX_DIM];
   logic [PXW-1:0] rd_upper_ff, rd_lower_ff;
   logic [PXW-1:0] win_ff [9];
   logic [PXW-1:0] px_ff;

   logic [DW-1:0]  dim_ff, dim_in, dim_m1;
   logic [AW-1:0]  in_col_ff, in_col_in;
   logic [RW-1:0]  in_row_ff, in_row_in;
   logic [AW-1:0]  oc_col_ff, oc_col_in;
   logic [AW-1:0]  oc_row_ff, oc_row_in;
   logic           col_wrap;
   int unsigned    size_raw;

   logic [SW-1:0]  sum_c [3];
   logic [SW-1:0]  num_ff [3];
   logic [1:0]     ncol, nrow;
   logic [3:0]     divisor_c;
   logic [MW-1:0]  recip_c, recip_ff;
   logic [PW-1:0]  prod [3];
   logic [CB-1:0]  quo_ff [3];
   logic           last_ff;
   logic [CB-1:0]  out_ff [3];

   // effective size, clamped
   always_comb begin
      size_raw = 32'(csr_image_size);
      if (size_raw < bf3_pkg::SIZE_MIN) begin
         dim_in = DW'(bf3_pkg::SIZE_MIN);
      end else if (size_raw > MAX_DIM) begin
         dim_in = DW'(MAX_DIM);
      end else begin
         dim_in = DW'(size_raw);
      end
   end

   assign dim_m1   = dim_ff - DW'(1);
   assign col_wrap = ({1'b0, in_col_ff} == dim_m1);

   assign sts.in_done  = (in_row_ff >= {1'b0, dim_ff});
   assign sts.emit_due = (in_row_ff >= RW'(2)) || ((in_row_ff == RW'(1)) && (in_col_ff != '0));
   assign sts.last_due = ({1'b0, oc_row_ff} == dim_m1) && ({1'b0, oc_col_ff} == dim_m1);

   // positions
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      oc_col_in = oc_col_ff;
      oc_row_in = oc_row_ff;
      if (cmd.clear || (cmd.emit && sts.last_due)) begin
         in_col_in = '0;
         in_row_in = '0;
         oc_col_in = '0;
         oc_row_in = '0;
      end else begin
         if (cmd.update) begin
            if (col_wrap) begin
               in_col_in = '0;
               in_row_in = in_row_ff + RW'(1);
            end else begin
               in_col_in = in_col_ff + AW'(1);
            end
         end
         if (cmd.emit) begin
            if ({1'b0, oc_col_ff} == dim_m1) begin
               oc_col_in = '0;
               oc_row_in = oc_row_ff + AW'(1);
            end else begin
               oc_col_in = oc_col_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= DW'(RESET_DIM);
         in_col_ff <= '0;
         in_row_ff <= '0;
         oc_col_ff <= '0;
         oc_row_ff <= '0;
      end else begin
         if (cmd.clear) begin
            dim_ff <= dim_in;
         end
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         oc_col_ff <= oc_col_in;
         oc_row_ff <= oc_row_in;
      end
   end

   // line stores: read every cycle, written on update
   always_ff @(posedge clock) begin
      rd_upper_ff <= upper_mem[in_col_ff];
      rd_lower_ff <= lower_mem[in_col_ff];
      if (cmd.update) begin
         upper_mem[in_col_ff] <= rd_lower_ff;
         lower_mem[in_col_ff] <= px_ff;
      end
   end

   // request capture; a late pixel counts as a flush
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (sts.in_done || req_cmd == bf3_pkg::CMD_FLUSH) begin
            px_ff <= '0;
         end else begin
            px_ff <= {req_in_blue[CB-1:0], req_in_green[CB-1:0], req_in_red[CB-1:0]};
         end
      end
   end

   // window: index col*3 + row, col 0 oldest, row 0 top
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_ff[i+3];
         end
         win_ff[6] <= rd_upper_ff;
         win_ff[7] <= rd_lower_ff;
         win_ff[8] <= px_ff;
      end
   end

   // clipped sums
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum_c[k] = '0;
      end
      for (int s = 0; s < 3; s++) begin
         for (int q = 0; q < 3; q++) begin
            if (!((s == 0 && oc_col_ff == '0) || (s == 2 && {1'b0, oc_col_ff} == dim_m1) ||
                  (q == 0 && oc_row_ff == '0) || (q == 2 && {1'b0, oc_row_ff} == dim_m1))) begin
               for (int k = 0; k < 3; k++) begin
                  sum_c[k] = sum_c[k] + SW'(win_ff[s*3+q][k*CB +: CB]);
               end
            end
         end
      end
      ncol = 2'd3 - ((oc_col_ff == '0) ? 2'd1 : 2'd0)
                  - (({1'b0, oc_col_ff} == dim_m1) ? 2'd1 : 2'd0);
      nrow = 2'd3 - ((oc_row_ff == '0) ? 2'd1 : 2'd0)
                  - (({1'b0, oc_row_ff} == dim_m1) ? 2'd1 : 2'd0);
      divisor_c = {2'b00, ncol} * {2'b00, nrow};
      case (divisor_c)
         DIV_INNER: recip_c = RECIP_9;
         DIV_EDGE:  recip_c = RECIP_6;
         default:   recip_c = RECIP_4;
      endcase
   end

   // reciprocal multiply, all three channels in parallel
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod[k] = PW'(num_ff[k]) * PW'(recip_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         recip_ff <= recip_c;
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= sum_c[k];
         end
      end
      if (cmd.div) begin
         for (int k = 0; k < 3; k++) begin
            quo_ff[k] <= prod[k][QSHIFT +: CB];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         for (int k = 0; k < 3; k++) begin
            out_ff[k] <= quo_ff[k];
         end
         last_ff <= sts.last_due;
      end
   end

   assign rsp_out_red    = 16'(out_ff[0]);
   assign rsp_out_green  = 16'(out_ff[1]);
   assign rsp_out_blue   = 16'(out_ff[2]);
   assign rsp_frame_last = last_ff;

endmodule

`default_nettype wire

@@ rtl/box_filter_3x3_rgb.sv @@
// Steps: a request that yields a result goes through update, sum, reciprocal
//   multiply and output load, and waits longer while a previous result is
//   still stalled.
// Requests: a new request is taken only in idle, after the previous one has
//   finished all its steps; one that yields no result only does the update.
// Reset: synchronous, active high; clears positions, window and handshakes,
//   image size returns to 64, or MAX_DIM if smaller. Line stores are not cleared.
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb
// Streaming 3x3 clipped mean filter over a square RGB image.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_3x3_rgb #(
   parameter int MAX_DIM      = 1024,
   parameter int CHANNEL_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_cmd,
   input  wire logic [15:0]                   req_in_red,
   input  wire logic [15:0]                   req_in_green,
   input  wire logic [15:0]                   req_in_blue,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [15:0]                        rsp_out_red,
   output logic [15:0]                        rsp_out_green,
   output logic [15:0]                        rsp_out_blue,
   output logic                               rsp_frame_last,
   // size register write
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bf3_pkg::SIZE_BITS-1:0] csr_image_size
);

   bf3_pkg::cmd_type    cmd;
   bf3_pkg::status_type sts;

   // sequencer: IDLE takes a request or a size write, then UPDATE shifts the
   // window and writes the line stores; requests that complete a neighborhood
   // go on through SUM, DIV and DONE.
   bf3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // line stores, window, positions, sums, divider, result register
   bf3_dp #(
      .MAX_DIM      (MAX_DIM),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_cmd        (req_cmd),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .csr_image_size (csr_image_size),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_last (rsp_frame_last)
   );

`ifndef NO_ASSERTIONS
   // a loaded result is offered the next cycle
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result register loaded but not offered");

   // every captured request is processed in the next cycle
   a_load_update: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.update)
      else $error("captured request not processed");

   // closing result restarts the frame
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.last_due) |=> (!sts.in_done && !sts.emit_due))
      else $error("frame not restarted after last result");
`endif

endmodule

`default_nettype wire
